/* hdl/scc_pkg.sv */
// Shared types, constants and CRC-8 helpers for the settings slice codec.
// No dependencies; every other file in hdl/ imports this package.
package scc_pkg;

  localparam int MaxSlices  = 256;
  localparam int SliceBytes = 8;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] PadByte = 8'hFF;

  localparam logic [11:0] TotalBytesReset = 12'd256;

  // Record size limit in bytes, kept wide enough for the largest slice count
  localparam logic [15:0] LimitBytes = 16'(MaxSlices * SliceBytes);

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } scc_cmd_e;

  // One slice as it travels down the pipeline
  typedef struct packed {
    scc_cmd_e    cmd;
    logic [63:0] setting;
    logic [63:0] dflt;
    logic [63:0] message;
    logic [7:0]  stored;
    logic [7:0]  mask;
    logic [63:0] enc;      // zero for decode
    logic [63:0] crc_msg;  // bytes still to be folded into the CRC, byte 0 lowest
    logic [7:0]  crc;
  } scc_item_t;

  // Result as it leaves the block
  typedef struct packed {
    logic        ok;
    logic [7:0]  mask;
    logic [63:0] restored;
    logic [7:0]  crc;
    logic [63:0] enc;
  } scc_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Fold four bytes, lowest byte first
  function automatic logic [7:0] crc8_word(input logic [7:0] crc, input logic [31:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 4; i++) begin
      c = crc8_byte(c, data[8*i +: 8]);
    end
    return c;
  endfunction

endpackage

/* hdl/scc_front.sv */
// First pipeline stage: byte mask from the record size, encode substitution,
// and choice of the bytes the CRC runs over. Depends on scc_pkg.
module scc_front
  import scc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [11:0] total_bytes_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  scc_cmd_e    cmd_i,
  input  logic [7:0]  slice_index_i,
  input  logic [63:0] setting_i,
  input  logic [63:0] dflt_i,
  input  logic [63:0] message_i,
  input  logic [7:0]  stored_i,
  output logic        valid_o,
  input  logic        ready_i,
  output scc_item_t   item_o
);

  logic        valid_q;
  scc_item_t   item_d, item_q;
  logic [15:0] size;
  logic [15:0] offset;
  logic [7:0]  mask;
  logic [63:0] enc;

  always_comb begin
    size   = ({4'd0, total_bytes_i} < LimitBytes) ? {4'd0, total_bytes_i} : LimitBytes;
    offset = {5'd0, slice_index_i, 3'd0};
    for (int i = 0; i < SliceBytes; i++) begin
      mask[i] = (offset + 16'(i)) < size;
    end
    for (int i = 0; i < SliceBytes; i++) begin
      enc[8*i +: 8] = (mask[i] && (setting_i[8*i +: 8] != dflt_i[8*i +: 8])) ?
                      setting_i[8*i +: 8] : PadByte;
    end

    item_d.cmd     = cmd_i;
    item_d.setting = setting_i;
    item_d.dflt    = dflt_i;
    item_d.message = message_i;
    item_d.stored  = stored_i;
    item_d.mask    = mask;
    item_d.enc     = (cmd_i == CMD_DECODE) ? 64'd0 : enc;
    item_d.crc_msg = (cmd_i == CMD_DECODE) ? message_i : enc;
    item_d.crc     = CrcInit;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

/* hdl/scc_crc_stage.sv */
// CRC pipeline stage: folds the next four message bytes into the running
// CRC-8 and shifts them out of the pending word. Depends on scc_pkg.
module scc_crc_stage
  import scc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  scc_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output scc_item_t item_o
);

  logic      valid_q;
  scc_item_t item_d, item_q;

  always_comb begin
    item_d         = item_i;
    item_d.crc     = crc8_word(item_i.crc, item_i.crc_msg[31:0]);
    item_d.crc_msg = {32'd0, item_i.crc_msg[63:32]};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

/* hdl/scc_back.sv */
// Last pipeline stage and output register: checksum compare and default
// substitution on decode. Depends on scc_pkg.
module scc_back
  import scc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  scc_item_t   item_i,
  output logic        valid_o,
  input  logic        ready_i,
  output scc_result_t result_o
);

  logic        valid_q;
  scc_result_t result_d, result_q;
  logic        ok;
  logic [63:0] restored;

  always_comb begin
    ok = (item_i.cmd == CMD_DECODE) ? (item_i.crc == item_i.stored) : 1'b1;
    for (int i = 0; i < SliceBytes; i++) begin
      if (item_i.cmd == CMD_ENCODE) begin
        restored[8*i +: 8] = 8'd0;
      end else if (!item_i.mask[i]) begin
        restored[8*i +: 8] = item_i.setting[8*i +: 8];
      end else if ((item_i.message[8*i +: 8] == PadByte) || !ok) begin
        restored[8*i +: 8] = item_i.dflt[8*i +: 8];
      end else begin
        restored[8*i +: 8] = item_i.message[8*i +: 8];
      end
    end
    result_d.ok       = ok;
    result_d.mask     = item_i.mask;
    result_d.restored = restored;
    result_d.crc      = item_i.crc;
    result_d.enc      = item_i.enc;
  end

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_d;
    end
  end

endmodule

/* hdl/settings_slice_codec_crc8_top.sv */
// Settings slice codec, CRC-8 (poly 0x31, init 0xFF): four register stages.
// Throughput 1 slice/cycle while the output side takes each result (m_axis_tready_i high).
// Stages: mask and encode, CRC over bytes 0..3, CRC over bytes 4..7, compare/restore.
// Each stage takes a new slice when it is empty or its successor takes its slice.
// Reset empties the pipeline and sets total_bytes to 256. Depends on scc_pkg.
module settings_slice_codec_crc8_top
  import scc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [11:0]  cfg_data_i,      // total_bytes
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // slice_index[7:0], setting_bytes[71:8], default_bytes[135:72],
  // message_bytes[199:136], stored_checksum[207:200]
  input  logic [207:0] s_axis_tdata_i,
  input  logic [0:0]   s_axis_tuser_i,  // command[0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // encoded_bytes[63:0], encoded_checksum[71:64], restored_bytes[135:72],
  // byte_mask[143:136], checksum_ok[144], zero[151:145]
  output logic [151:0] m_axis_tdata_o
);

  logic [11:0] total_bytes_q;

  logic        front_valid, front_ready;
  logic        lo_valid, lo_ready;
  logic        hi_valid, hi_ready;
  scc_item_t   front_item, lo_item, hi_item;
  scc_result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_bytes_q <= TotalBytesReset;
    end else if (cfg_valid_i) begin
      total_bytes_q <= cfg_data_i;
    end
  end

  scc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .total_bytes_i (total_bytes_q),
    .valid_i       (s_axis_tvalid_i),
    .ready_o       (s_axis_tready_o),
    .cmd_i         (scc_cmd_e'(s_axis_tuser_i[0])),
    .slice_index_i (s_axis_tdata_i[7:0]),
    .setting_i     (s_axis_tdata_i[71:8]),
    .dflt_i        (s_axis_tdata_i[135:72]),
    .message_i     (s_axis_tdata_i[199:136]),
    .stored_i      (s_axis_tdata_i[207:200]),
    .valid_o       (front_valid),
    .ready_i       (front_ready),
    .item_o        (front_item)
  );

  scc_crc_stage u_crc_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .item_i  (front_item),
    .valid_o (lo_valid),
    .ready_i (lo_ready),
    .item_o  (lo_item)
  );

  scc_crc_stage u_crc_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lo_valid),
    .ready_o (lo_ready),
    .item_i  (lo_item),
    .valid_o (hi_valid),
    .ready_i (hi_ready),
    .item_o  (hi_item)
  );

  scc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (hi_valid),
    .ready_o  (hi_ready),
    .item_i   (hi_item),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (result)
  );

  assign m_axis_tdata_o = {7'd0, result.ok, result.mask, result.restored,
                           result.crc, result.enc};

  // An accepted transaction always lands in the first stage
  a_front_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> front_valid)
    else $error("accepted slice did not enter the first stage");

  // Only a decode can fail the check, and a decode has no encoded bytes
  a_fail_is_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !result.ok |-> result.enc == 64'd0)
    else $error("checksum failure reported on an encode result");

  // Bytes below the record size form a run from byte 0
  a_mask_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (result.mask & (result.mask + 8'd1)) == 8'd0)
    else $error("byte mask is not a contiguous run from byte 0");

endmodule

/* dv/settings_slice_codec_crc8_top_test.sv */
// Self-checking testbench for settings_slice_codec_crc8_top: drives slice transactions,
// predicts each result from a local codec model and checks the result stream in order.
// Depends on scc_pkg (command enum) and the block's RTL.
module settings_slice_codec_crc8_top_test;
  import scc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeLatency = 4;
  localparam int RecordLimit = 2048;   // 256 slices of 8 bytes
  localparam int DrainCycles = 5000;
  localparam logic [7:0] Crc8Poly = 8'h31;
  localparam logic [7:0] Crc8Seed = 8'hFF;
  localparam logic [7:0] EmptyByte = 8'hFF;

  typedef struct packed {
    scc_cmd_e    cmd;
    logic [7:0]  slice_index;
    logic [63:0] setting;
    logic [63:0] dflt;
    logic [63:0] message;
    logic [7:0]  stored;
  } slice_req_t;

  typedef struct packed {
    logic [63:0] enc;
    logic [7:0]  crc;
    logic [63:0] restored;
    logic [7:0]  mask;
    logic        ok;
  } slice_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [11:0]  cfg_data_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [207:0] s_axis_tdata_i;
  logic [0:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [151:0] m_axis_tdata_o;

  slice_res_t   expected_q[$];
  logic [11:0]  record_size;
  bit           steady_flow;
  int           mismatches;

  settings_slice_codec_crc8_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #1;
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
  end

  // CRC-8, MSB first, byte 0 folded in first, no reflection and no final xor
  function automatic logic [7:0] slice_crc8(logic [63:0] msg);
    logic [7:0] c;
    int i, b;
    c = Crc8Seed;
    for (i = 0; i < 8; i++) begin
      c = c ^ msg[8*i +: 8];
      for (b = 0; b < 8; b++) begin
        c = c[7] ? ((c << 1) ^ Crc8Poly) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic slice_res_t codec_predict(slice_req_t r);
    slice_res_t res;
    int size, offset, i;
    logic [7:0] s, d, m;
    size = (int'(record_size) < RecordLimit) ? int'(record_size) : RecordLimit;
    offset = int'(r.slice_index) * 8;
    res = '0;
    for (i = 0; i < 8; i++) begin
      res.mask[i] = (offset + i) < size;
    end
    if (r.cmd == CMD_ENCODE) begin
      for (i = 0; i < 8; i++) begin
        s = r.setting[8*i +: 8];
        d = r.dflt[8*i +: 8];
        res.enc[8*i +: 8] = (res.mask[i] && s != d) ? s : EmptyByte;
      end
      res.crc = slice_crc8(res.enc);
      res.ok = 1'b1;
    end else begin
      res.crc = slice_crc8(r.message);
      res.ok = (res.crc == r.stored);
      for (i = 0; i < 8; i++) begin
        s = r.setting[8*i +: 8];
        d = r.dflt[8*i +: 8];
        m = r.message[8*i +: 8];
        if (!res.mask[i]) begin
          res.restored[8*i +: 8] = s;
        end else if (m == EmptyByte || !res.ok) begin
          res.restored[8*i +: 8] = d;
        end else begin
          res.restored[8*i +: 8] = m;
        end
      end
    end
    return res;
  endfunction

  function automatic slice_req_t make_slice(scc_cmd_e cmd, logic [7:0] idx, logic [63:0] setting,
                                            logic [63:0] dflt, logic [63:0] message,
                                            logic [7:0] stored);
    slice_req_t r;
    r.cmd = cmd;
    r.slice_index = idx;
    r.setting = setting;
    r.dflt = dflt;
    r.message = message;
    r.stored = stored;
    return r;
  endfunction

  // Random bytes with extra weight on 0x00 and 0xFF
  function automatic logic [63:0] rand_bytes();
    logic [63:0] v;
    int i;
    v = {$urandom, $urandom};
    for (i = 0; i < 8; i++) begin
      case ($urandom_range(9))
        0: v[8*i +: 8] = 8'hFF;
        1: v[8*i +: 8] = 8'h00;
        default: ;
      endcase
    end
    return v;
  endfunction

  // Slice index that often lands next to the end of the record
  function automatic logic [7:0] pick_slice();
    int size, idx;
    size = (int'(record_size) < RecordLimit) ? int'(record_size) : RecordLimit;
    if ($urandom_range(1) == 0) begin
      idx = size / 8 + int'($urandom_range(2)) - 1;
      if (idx < 0) idx = 0;
      if (idx > 255) idx = 255;
      return 8'(idx);
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic slice_req_t rand_slice();
    slice_req_t r;
    slice_res_t enc;
    int i;
    r.slice_index = pick_slice();
    r.dflt = rand_bytes();
    r.setting = rand_bytes();
    for (i = 0; i < 8; i++) begin
      if ($urandom_range(9) < 3) r.setting[8*i +: 8] = r.dflt[8*i +: 8];
    end
    r.cmd = CMD_ENCODE;
    r.message = rand_bytes();
    r.stored = 8'($urandom);
    if ($urandom_range(1) == 1) begin
      r.cmd = CMD_DECODE;
      // in half the cases an encoded record as message, and mostly stored with its own CRC
      if ($urandom_range(9) < 5) begin
        enc = codec_predict(make_slice(CMD_ENCODE, r.slice_index, r.setting, r.dflt, '0, '0));
        r.message = enc.enc;
      end
      if ($urandom_range(9) < 7) r.stored = slice_crc8(r.message);
    end
    return r;
  endfunction

  task automatic send_slice(slice_req_t r);
    if (!steady_flow && $urandom_range(99) < 15) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {r.stored, r.message, r.dflt, r.setting, r.slice_index};
    s_axis_tuser_i <= r.cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(codec_predict(r));
  endtask

  // Hold off input and let the pipeline empty
  task automatic drain_results();
    int n;
    s_axis_tvalid_i <= 1'b0;
    n = 0;
    while (expected_q.size() != 0 && n < DrainCycles) begin
      @(posedge clk_i);
      n++;
    end
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_record_size(logic [11:0] size);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    record_size = size;
  endtask

  task automatic check_result(logic [151:0] data);
    slice_res_t want, got;
    got.enc = data[63:0];
    got.crc = data[71:64];
    got.restored = data[135:72];
    got.mask = data[143:136];
    got.ok = data[144];
    if (expected_q.size() == 0) begin
      if (mismatches < 10) $display("mismatch: unexpected result %h", data);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      if (got.enc !== want.enc || got.crc !== want.crc || got.restored !== want.restored ||
          got.mask !== want.mask || got.ok !== want.ok) begin
        if (mismatches < 10) begin
          $display("mismatch: enc %h/%h crc %h/%h restored %h/%h mask %h/%h ok %b/%b",
                   want.enc, got.enc, want.crc, got.crc, want.restored, got.restored,
                   want.mask, got.mask, want.ok, got.ok);
        end
        mismatches++;
      end
    end
  endtask

  // Result sink: check each transaction, stall at random unless in a steady stretch
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
    m_axis_tready_i <= steady_flow || ($urandom_range(99) >= 15);
  end

  // Reset size of 256 bytes: slices 0..31 in the record, 32 and up padding
  task automatic test_reset_defaults();
    logic [63:0] a, b;
    a = 64'h0123_4567_89AB_CDEF;
    b = 64'hFF00_55AA_0102_FEFF;
    send_slice(make_slice(CMD_ENCODE, 8'd0, '0, '0, '0, '0));
    send_slice(make_slice(CMD_ENCODE, 8'd0, '1, '0, '0, '0));
    send_slice(make_slice(CMD_ENCODE, 8'd0, '0, '1, '1, '1));
    send_slice(make_slice(CMD_ENCODE, 8'd1, a, ~a, '0, '0));
    send_slice(make_slice(CMD_ENCODE, 8'd31, a, {a[63:32], ~a[31:0]}, '0, '0));
    send_slice(make_slice(CMD_ENCODE, 8'd32, a, ~a, '0, '0));
    send_slice(make_slice(CMD_ENCODE, 8'd255, '1, '0, '1, '1));
    send_slice(make_slice(CMD_DECODE, 8'd0, a, b, '1, slice_crc8('1)));
    send_slice(make_slice(CMD_DECODE, 8'd0, a, b, '0, slice_crc8('0)));
    send_slice(make_slice(CMD_DECODE, 8'd5, a, b, b, slice_crc8(b)));
    send_slice(make_slice(CMD_DECODE, 8'd5, a, b, a, slice_crc8(a) ^ 8'h01));
    send_slice(make_slice(CMD_DECODE, 8'd31, b, a, a, slice_crc8(a) ^ 8'h80));
    send_slice(make_slice(CMD_DECODE, 8'd31, '0, '1, '1, 8'h00));
    send_slice(make_slice(CMD_DECODE, 8'd32, a, b, b, slice_crc8(b)));
    send_slice(make_slice(CMD_DECODE, 8'd255, '1, '1, '1, '1));
    send_slice(make_slice(CMD_DECODE, 8'd16, '0, '0, '0, '0));
    send_slice(make_slice(CMD_DECODE, 8'd17, ~a, ~b, ~a, slice_crc8(~a)));
    send_slice(make_slice(CMD_ENCODE, 8'd17, ~b, ~b, '0, '0));
  endtask

  // Sizes at and around the edges, with slices around the last partial one
  task automatic test_record_sizes();
    logic [11:0] sizes[10];
    int k, j;
    sizes = '{12'd0, 12'd1, 12'd7, 12'd8, 12'd13, 12'd2047, 12'd2048, 12'd2049,
              12'd4095, 12'd1000};
    for (k = 0; k < 10; k++) begin
      drain_results();
      write_record_size(sizes[k]);
      for (j = 0; j < 5; j++) begin
        send_slice(rand_slice());
      end
      send_slice(make_slice(CMD_ENCODE, 8'd255, rand_bytes(), rand_bytes(), '0, '0));
      send_slice(make_slice(CMD_DECODE, 8'd0, rand_bytes(), rand_bytes(), '1, slice_crc8('1)));
    end
  endtask

  task automatic test_random_traffic();
    int phase, j;
    logic [11:0] size;
    for (phase = 0; phase < 10; phase++) begin
      drain_results();
      case ($urandom_range(7))
        0: size = 12'd2048;
        1: size = 12'($urandom_range(4095, 2049));
        2: size = 12'($urandom_range(64, 1));
        default: size = 12'($urandom_range(2048, 1));
      endcase
      write_record_size(size);
      steady_flow = (phase == 4);
      for (j = 0; j < 126; j++) begin
        send_slice(rand_slice());
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= CMD_ENCODE;
    m_axis_tready_i <= 1'b0;
    record_size = 12'd256;
    steady_flow = 1'b0;
    mismatches = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_record_sizes();
    test_random_traffic();
    drain_results();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
hdl/scc_pkg.sv
hdl/scc_front.sv
hdl/scc_crc_stage.sv
hdl/scc_back.sv
hdl/settings_slice_codec_crc8_top.sv
dv/settings_slice_codec_crc8_top_test.sv
